// ===== rtl/core/polyphonic_adsr_envelope_macros.svh =====
// assertion macros for the polyphonic envelope checker
`ifndef POLYPHONIC_ADSR_ENVELOPE_MACROS_SVH
`define POLYPHONIC_ADSR_ENVELOPE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pae_pkg.sv =====
// shared types and constants of the polyphonic envelope generator
package pae_pkg;

    // request commands
    typedef enum logic [2:0] {
        CMD_KEY_PRESS   = 3'd0,
        CMD_KEY_RELEASE = 3'd1,
        CMD_SEQ_PRESS   = 3'd2,
        CMD_SEQ_RELEASE = 3'd3,
        CMD_TICK        = 3'd4
    } t_cmd;

    // envelope stages
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ATTACK_STEP   = 3'd0,
        CFG_DECAY_STEP    = 3'd1,
        CFG_SUSTAIN_VALUE = 3'd2,
        CFG_RELEASE_STEP  = 3'd3,
        CFG_PEAK_LEVEL    = 3'd4,
        CFG_DECAY_FLOOR   = 3'd5,
        CFG_SILENCE_FLOOR = 3'd6,
        CFG_RELEASE_START = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_W   = 16;
    localparam int NOTE_W    = 7;
    localparam int VOICE_W   = 4;
    localparam int RES_CAP   = 12;
    localparam int CNT_W     = 4;

    // result kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_value;
        logic [LEVEL_W-1:0] release_step;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] decay_floor;
        logic [LEVEL_W-1:0] silence_floor;
        logic [LEVEL_W-1:0] release_start;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        attack_step:   16'd256,
        decay_step:    16'd128,
        sustain_value: 16'd32768,
        release_step:  16'd128,
        peak_level:    16'd65535,
        decay_floor:   16'd32768,
        silence_floor: 16'd0,
        release_start: 16'd0
    };

    // one voice entry as held in the voice memory
    typedef struct packed {
        logic               pressed;
        logic               sounding;
        t_stage             stage;
        logic [NOTE_W-1:0]  note;
        logic [LEVEL_W-1:0] level;
    } t_voice;

    localparam t_voice VOICE_RESET = '{
        pressed:  1'b0,
        sounding: 1'b0,
        stage:    ST_IDLE,
        note:     7'd0,
        level:    16'd0
    };

    // one result item without its last flag
    typedef struct packed {
        logic               kind;
        logic [VOICE_W-1:0] voice;
        logic               accepted;
        logic [NOTE_W-1:0]  note;
        logic [LEVEL_W-1:0] level;
        t_stage             stage;
        logic               sounding;
    } t_result;

endpackage

// ===== rtl/core/pae_voice_update.sv =====
// per-voice update for press, release and envelope tick requests
module pae_voice_update
    import pae_pkg::*;
(
    input  t_cmd              i_cmd,
    input  logic [NOTE_W-1:0] i_key,
    input  logic              i_in_key_grp,
    input  logic              i_claim_ok,
    input  t_cfg              i_cfg,
    input  t_voice            i_voice,
    output t_voice            o_voice,
    output logic              o_hit
);

    logic                  grp_match;
    logic [LEVEL_W:0]      att_sum;
    logic signed [LEVEL_W+1:0] dec_diff;
    logic signed [LEVEL_W+1:0] rel_diff;

    // group of the request
    assign grp_match = (i_cmd == CMD_KEY_PRESS || i_cmd == CMD_KEY_RELEASE) ?
                       i_in_key_grp : !i_in_key_grp;

    // envelope arithmetic
    assign att_sum  = {1'b0, i_voice.level} + {1'b0, i_cfg.attack_step};
    assign dec_diff = $signed({2'b00, i_voice.level}) - $signed({2'b00, i_cfg.decay_step});
    assign rel_diff = $signed({2'b00, i_voice.level}) - $signed({2'b00, i_cfg.release_step});

    always_comb begin
        o_voice = i_voice;
        o_hit   = 1'b0;
        case (i_cmd) inside
            CMD_KEY_PRESS, CMD_SEQ_PRESS: begin
                // claim the first free voice of the group
                if (grp_match && !i_voice.pressed && i_claim_ok) begin
                    o_voice.pressed  = 1'b1;
                    o_voice.sounding = 1'b1;
                    o_voice.stage    = ST_ATTACK;
                    o_voice.note     = i_key;
                    o_hit            = 1'b1;
                end
            end
            CMD_KEY_RELEASE, CMD_SEQ_RELEASE: begin
                // every pressed voice of the group holding the key goes to release
                if (grp_match && i_voice.pressed && i_voice.note == i_key) begin
                    o_voice.pressed = 1'b0;
                    o_voice.stage   = ST_RELEASE;
                    if (i_cmd == CMD_KEY_RELEASE) begin
                        o_voice.level = i_cfg.release_start;
                    end
                    o_hit = 1'b1;
                end
            end
            CMD_TICK: begin
                if (i_voice.sounding) begin
                    o_hit = 1'b1;
                    case (i_voice.stage)
                        ST_ATTACK: begin
                            if (att_sum >= {1'b0, i_cfg.peak_level}) begin
                                o_voice.level = i_cfg.peak_level;
                                o_voice.stage = ST_DECAY;
                            end else begin
                                o_voice.level = att_sum[LEVEL_W-1:0];
                            end
                        end
                        ST_DECAY: begin
                            if (dec_diff <= $signed({2'b00, i_cfg.decay_floor})) begin
                                o_voice.level = i_cfg.decay_floor;
                                o_voice.stage = ST_SUSTAIN;
                            end else begin
                                o_voice.level = dec_diff[LEVEL_W-1:0];
                            end
                        end
                        ST_SUSTAIN: begin
                            o_voice.level = i_cfg.sustain_value;
                        end
                        ST_RELEASE: begin
                            if (rel_diff < $signed({2'b00, i_cfg.silence_floor})) begin
                                o_voice.level    = i_cfg.silence_floor;
                                o_voice.stage    = ST_IDLE;
                                o_voice.sounding = 1'b0;
                            end else begin
                                o_voice.level = rel_diff[LEVEL_W-1:0];
                            end
                        end
                        default: begin
                            // sounding while idle: silence it
                            o_voice.level    = i_cfg.silence_floor;
                            o_voice.stage    = ST_IDLE;
                            o_voice.sounding = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/polyphonic_adsr_envelope.sv =====
// Polyphonic envelope generator: keyboard voices followed by sequencer voices, all
// held in one voice memory. A request is taken when start is high and busy is low;
// every request except an unused command code sweeps the whole memory, one voice
// per cycle (read, update, write back), and keeps busy high through the sweep and
// a closing finish state. An unused command code is taken and dropped at once.
// Results come out one per cycle on o_strobe, the last one with o_last, and cannot
// be held off: a receiver must take each one in the cycle it is shown. Results of a
// sweep appear while busy is high, the final one in the first cycle with busy low.
// Configuration writes are taken in any cycle and belong in idle periods.
module polyphonic_adsr_envelope
    import pae_pkg::*;
#(
    parameter int KEY_VOICES      = 8,
    parameter int SEQ_VOICE_COUNT = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_command,
    input  logic [NOTE_W-1:0]    i_key,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    output logic                 o_strobe,
    output logic                 o_kind,
    output logic [VOICE_W-1:0]   o_voice,
    output logic                 o_accepted,
    output logic [NOTE_W-1:0]    o_note,
    output logic [LEVEL_W-1:0]   o_level,
    output logic [2:0]           o_stage,
    output logic                 o_sounding,
    output logic                 o_last
);

    localparam int TOTAL = KEY_VOICES + SEQ_VOICE_COUNT;
    localparam int VW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam logic [VW-1:0] LAST_ADDR = VW'(TOTAL - 1);
    localparam logic [VW:0]   KEY_LIM   = (VW+1)'(KEY_VOICES);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_cfg              r_cfg;
    t_cmd              r_cmd;
    logic [NOTE_W-1:0] r_key;

    // voice memory and its written marks
    t_voice            r_mem [TOTAL];
    logic [TOTAL-1:0]  r_vbit;
    t_voice            r_rd_data;
    logic              r_rd_vbit;

    // sweep pipeline
    logic [VW-1:0]     r_rd_addr;
    logic              r_rd_done;
    logic              r_ev_vld;
    logic              r_ev_last;
    logic [VW-1:0]     r_ev_addr;

    // result collection
    logic              r_found;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend_vld;
    t_result           r_pend;

    // output register
    logic              r_o_strobe;
    logic              r_o_last;
    t_result           r_o_res;

    logic              accept;
    logic              rd_en;
    logic              in_key_grp;
    t_voice            ev_voice;
    t_voice            upd_voice;
    logic              upd_hit;
    logic              record;
    t_result           new_res;
    t_result           fail_res;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign rd_en  = (r_state == S_SWEEP) && !r_rd_done;

    // unwritten entries read as the reset voice
    assign ev_voice   = r_rd_vbit ? r_rd_data : VOICE_RESET;
    assign in_key_grp = ({1'b0, r_ev_addr} < KEY_LIM);

    pae_voice_update u_upd (
        .i_cmd        (r_cmd),
        .i_key        (r_key),
        .i_in_key_grp (in_key_grp),
        .i_claim_ok   (!r_found),
        .i_cfg        (r_cfg),
        .i_voice      (ev_voice),
        .o_voice      (upd_voice),
        .o_hit        (upd_hit)
    );

    assign record = r_ev_vld && upd_hit && (r_cnt < CNT_W'(RES_CAP));

    // result built from the updated voice
    always_comb begin
        new_res.kind     = (r_cmd == CMD_TICK) ? KIND_TICK : KIND_ACK;
        new_res.voice    = VOICE_W'(r_ev_addr);
        new_res.accepted = 1'b1;
        new_res.note     = upd_voice.note;
        new_res.level    = upd_voice.level;
        new_res.stage    = upd_voice.stage;
        new_res.sounding = upd_voice.sounding;
    end

    // acknowledge for a press with no free voice or a release with no match
    always_comb begin
        fail_res.kind     = KIND_ACK;
        fail_res.voice    = '0;
        fail_res.accepted = 1'b0;
        fail_res.note     = r_key;
        fail_res.level    = '0;
        fail_res.stage    = ST_IDLE;
        fail_res.sounding = 1'b0;
    end

    // sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_command <= CMD_TICK) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_ev_vld && r_ev_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // voice memory: one read and one write back per cycle
    always_ff @(posedge i_clk) begin
        if (r_ev_vld) begin
            r_mem[r_ev_addr] <= upd_voice;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= CFG_RESET;
            r_vbit     <= '0;
            r_rd_done  <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_ev_last  <= 1'b0;
            r_found    <= 1'b0;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_o_strobe <= 1'b0;
            r_o_last   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_o_strobe <= 1'b0;
            r_o_last   <= 1'b0;

            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ATTACK_STEP:   r_cfg.attack_step   <= i_cfg_data;
                    CFG_DECAY_STEP:    r_cfg.decay_step    <= i_cfg_data;
                    CFG_SUSTAIN_VALUE: r_cfg.sustain_value <= i_cfg_data;
                    CFG_RELEASE_STEP:  r_cfg.release_step  <= i_cfg_data;
                    CFG_PEAK_LEVEL:    r_cfg.peak_level    <= i_cfg_data;
                    CFG_DECAY_FLOOR:   r_cfg.decay_floor   <= i_cfg_data;
                    CFG_SILENCE_FLOOR: r_cfg.silence_floor <= i_cfg_data;
                    CFG_RELEASE_START: r_cfg.release_start <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // new request
            if (accept) begin
                r_rd_done  <= 1'b0;
                r_found    <= 1'b0;
                r_cnt      <= '0;
                r_pend_vld <= 1'b0;
            end

            // read side of the sweep
            r_ev_vld  <= rd_en;
            r_ev_last <= rd_en && (r_rd_addr == LAST_ADDR);
            if (rd_en && r_rd_addr == LAST_ADDR) begin
                r_rd_done <= 1'b1;
            end

            // update side: mark written entries and collect results
            if (r_ev_vld) begin
                r_vbit[r_ev_addr] <= 1'b1;
                if (upd_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (record) begin
                r_cnt      <= r_cnt + 1'b1;
                r_pend_vld <= 1'b1;
                if (r_pend_vld) begin
                    r_o_strobe <= 1'b1;
                end
            end

            // closing result of the request
            if (r_state == S_FINISH) begin
                if (r_pend_vld || r_cmd != CMD_TICK) begin
                    r_o_strobe <= 1'b1;
                    r_o_last   <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= t_cmd'(i_command);
            r_key     <= i_key;
            r_rd_addr <= '0;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        r_rd_vbit <= r_vbit[r_rd_addr];
        r_ev_addr <= r_rd_addr;
        if (record) begin
            r_pend <= new_res;
            r_o_res <= r_pend;
        end
        if (r_state == S_FINISH) begin
            r_o_res <= r_pend_vld ? r_pend : fail_res;
        end
    end

    assign o_strobe   = r_o_strobe;
    assign o_last     = r_o_last;
    assign o_kind     = r_o_res.kind;
    assign o_voice    = r_o_res.voice;
    assign o_accepted = r_o_res.accepted;
    assign o_note     = r_o_res.note;
    assign o_level    = r_o_res.level;
    assign o_stage    = r_o_res.stage;
    assign o_sounding = r_o_res.sounding;

endmodule

// ===== rtl/core/pae_checker.sv =====
// port-level checks of the polyphonic envelope generator and their binding
`include "polyphonic_adsr_envelope_macros.svh"

module pae_checker
    import pae_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         i_command,
    input logic               o_strobe,
    input logic               o_kind,
    input logic [VOICE_W-1:0] o_voice,
    input logic               o_accepted,
    input logic               o_last
);

    // results only follow a cycle of sweep activity
    `PAE_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n,
        o_strobe, $past(busy), "result outside a request")

    // a request with a known command starts a sweep
    `PAE_ASSERT_NEXT(a_sweep_starts, i_clk, i_rst_n,
        start && !busy && i_command <= CMD_TICK, busy, "request not started")

    // an unused command is dropped without a sweep
    `PAE_ASSERT_NEXT(a_unused_dropped, i_clk, i_rst_n,
        start && !busy && i_command > CMD_TICK, !busy && !o_strobe,
        "unused command started a sweep")

    // a refused request gives a single closing acknowledge on voice zero
    `PAE_ASSERT_NOW(a_refused_shape, i_clk, i_rst_n,
        o_strobe && !o_accepted, o_last && o_kind == KIND_ACK && o_voice == '0,
        "malformed refusal")

    // tick reports are always accepted
    `PAE_ASSERT_NOW(a_tick_accepted, i_clk, i_rst_n,
        o_strobe && o_kind == KIND_TICK, o_accepted, "tick report not accepted")

endmodule

bind polyphonic_adsr_envelope pae_checker u_pae_checker (.*);
